[rtl/ldpm_pkg.sv]
// ----------------------------------------------------------------------------
// ldpm_pkg - shared definitions for the lens distortion point map
// Field widths, register indexes, divider geometry and the normalizer result.
// ----------------------------------------------------------------------------
package ldpm_pkg;

	// Field widths.
	localparam int COORD_W    = 24;
	localparam int FOCAL_W    = 24;
	localparam int COEF_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Normalized values are signed Q.24 and clamped to +/-2.0.
	localparam int NORM_Q_W = 26;
	localparam int NORM_W   = NORM_Q_W + 1;
	localparam logic [NORM_Q_W-1:0] NORM_LIMIT = NORM_Q_W'(1) << (NORM_Q_W - 1);

	// The long division retires this many quotient bits per pipeline stage.
	localparam int NORM_BITS_PER_STAGE = 2;
	localparam int NORM_STAGES         = NORM_Q_W / NORM_BITS_PER_STAGE;

	// Normalizer: difference stage, numerator stage, divider stages, clamp stage.
	localparam int NORM_LATENCY = NORM_STAGES + 3;
	// Stages from the normalized point to the result ports.
	localparam int POST_LATENCY = 10;
	localparam int PIPE_LATENCY = NORM_LATENCY + POST_LATENCY;

	// Register reset values.
	localparam logic [FOCAL_W-1:0] FOCAL_RESET = FOCAL_W'(256);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOCAL_X = 3'd0,
		REG_FOCAL_Y = 3'd1,
		REG_CENTRE_X = 3'd2,
		REG_CENTRE_Y = 3'd3,
		REG_RADIAL_K1 = 3'd4,
		REG_RADIAL_K2 = 3'd5,
		REG_TANGENTIAL_P1 = 3'd6,
		REG_TANGENTIAL_P2 = 3'd7
	} cfg_reg_t;

	// Normalizer result as seen by the top level.
	typedef struct packed {
		logic                     valid;
		logic                     sat;
		logic signed [NORM_W-1:0] value;
	} norm_t;

endpackage

[rtl/ldpm_norm.sv]
// ----------------------------------------------------------------------------
// ldpm_norm - pipelined coordinate normalizer
// Computes round((pix - centre) / focal) in signed Q.24 with a pipelined
// restoring divider, clamping the magnitude to 2.0.
// ----------------------------------------------------------------------------
module ldpm_norm
	import ldpm_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req,
	input  logic signed [COORD_W-1:0] pix,
	input  logic [FOCAL_W-1:0]        centre,
	input  logic [FOCAL_W-1:0]        focal,
	output norm_t                     result
);

	// Divider stage payload: remainder and the shared numerator/quotient word.
	typedef struct packed {
		logic                neg;
		logic                ovf;
		logic [FOCAL_W-1:0]  rem;
		logic [NORM_Q_W-1:0] nq;
	} div_t;

	// Stage 1: signed difference and its magnitude.
	logic signed [COORD_W+1:0] diff;
	logic                      valid_s1;
	logic                      neg_s1;
	logic [COORD_W:0]          mag_s1;

	assign diff = $signed({{2{pix[COORD_W-1]}}, pix}) - $signed({2'b00, centre});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= diff[COORD_W+1];
		mag_s1 <= diff[COORD_W+1] ? 25'(-diff) : diff[COORD_W:0];
	end

	// Stage 2: rounded numerator and the quotient overflow test.
	logic [49:0] num;
	logic        ovf;
	logic        div_valid_s [0:NORM_STAGES];
	div_t        div_s       [0:NORM_STAGES];

	assign num = {1'b0, mag_s1, 24'd0} + {27'd0, focal[FOCAL_W-1:1]};
	assign ovf = num >= {focal, 26'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_valid_s[0] <= 1'b0;
		end else begin
			div_valid_s[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		div_s[0] <= '{neg: neg_s1, ovf: ovf, rem: num[49:26], nq: num[25:0]};
	end

	// Divider stages: each retires a few quotient bits, MSB first.
	for (genvar g = 1; g <= NORM_STAGES; g++) begin : g_div
		logic [FOCAL_W-1:0]  rem_w [0:NORM_BITS_PER_STAGE];
		logic [NORM_Q_W-1:0] nq_w  [0:NORM_BITS_PER_STAGE];
		logic [FOCAL_W:0]    trial [0:NORM_BITS_PER_STAGE-1];
		logic                ge    [0:NORM_BITS_PER_STAGE-1];

		assign rem_w[0] = div_s[g-1].rem;
		assign nq_w[0]  = div_s[g-1].nq;

		for (genvar j = 0; j < NORM_BITS_PER_STAGE; j++) begin : g_bit
			assign trial[j]   = {rem_w[j], nq_w[j][NORM_Q_W-1]};
			assign ge[j]      = trial[j] >= {1'b0, focal};
			assign rem_w[j+1] = ge[j] ? FOCAL_W'(trial[j] - {1'b0, focal})
			                          : trial[j][FOCAL_W-1:0];
			assign nq_w[j+1]  = {nq_w[j][NORM_Q_W-2:0], ge[j]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_valid_s[g] <= 1'b0;
			end else begin
				div_valid_s[g] <= div_valid_s[g-1];
			end
		end

		always_ff @(posedge clk) begin
			div_s[g] <= '{neg: div_s[g-1].neg, ovf: div_s[g-1].ovf,
			              rem: rem_w[NORM_BITS_PER_STAGE],
			              nq: nq_w[NORM_BITS_PER_STAGE]};
		end
	end

	// Final stage: clamp to 2.0 and restore the sign.
	logic [NORM_Q_W-1:0]      quot;
	logic                     big;
	logic signed [NORM_W-1:0] qmag;
	logic                     valid_q;
	logic                     sat_q;
	logic signed [NORM_W-1:0] value_q;

	assign quot = div_s[NORM_STAGES].nq;
	assign big  = div_s[NORM_STAGES].ovf || (quot > NORM_LIMIT);
	assign qmag = $signed({1'b0, big ? NORM_LIMIT : quot});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= div_valid_s[NORM_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		sat_q   <= big;
		value_q <= div_s[NORM_STAGES].neg ? -qmag : qmag;
	end

	assign result = '{valid: valid_q, sat: sat_q, value: value_q};

endmodule

[rtl/lens_distortion_point_map.sv]
// ----------------------------------------------------------------------------
// lens_distortion_point_map - Brown-Conrady point distortion (k1, k2, p1, p2)
// Maps an ideal pixel coordinate to its distorted position in fixed point.
// ----------------------------------------------------------------------------
//
//  channel   | control            | data
//  ----------+--------------------+--------------------------------
//  request   | start, busy        | in_x, in_y
//  result    | done               | out_x, out_y, saturated
//  config    | cfg_write          | cfg_index, cfg_data
//
//  A request is taken in every cycle; busy stays low.
//  Each result passes through the normalizer, with its 13-stage divider
//  at two quotient bits a stage, and then through 10 stages for the
//  multiplies, rounding and output clamp.
//  Reset clears all valid bits and returns the registers to their defaults.
//  Results are shown for one cycle with done; nothing stalls the pipeline.
//
module lens_distortion_point_map
	import ldpm_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [COORD_W-1:0]   in_x,
	input  logic signed [COORD_W-1:0]   in_y,
	output logic                        done,
	output logic signed [COORD_W-1:0]   out_x,
	output logic signed [COORD_W-1:0]   out_y,
	output logic                        saturated,
	input  logic                        cfg_write,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);

	// Configuration registers.
	logic [FOCAL_W-1:0]       focal_x_q;
	logic [FOCAL_W-1:0]       focal_y_q;
	logic [FOCAL_W-1:0]       centre_x_q;
	logic [FOCAL_W-1:0]       centre_y_q;
	logic signed [COEF_W-1:0] k1_q;
	logic signed [COEF_W-1:0] k2_q;
	logic signed [COEF_W-1:0] p1_q;
	logic signed [COEF_W-1:0] p2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= FOCAL_RESET;
			focal_y_q  <= FOCAL_RESET;
			centre_x_q <= '0;
			centre_y_q <= '0;
			k1_q       <= '0;
			k2_q       <= '0;
			p1_q       <= '0;
			p2_q       <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FOCAL_X:       focal_x_q  <= cfg_data[FOCAL_W-1:0];
				REG_FOCAL_Y:       focal_y_q  <= cfg_data[FOCAL_W-1:0];
				REG_CENTRE_X:      centre_x_q <= cfg_data[FOCAL_W-1:0];
				REG_CENTRE_Y:      centre_y_q <= cfg_data[FOCAL_W-1:0];
				REG_RADIAL_K1:     k1_q       <= $signed(cfg_data);
				REG_RADIAL_K2:     k2_q       <= $signed(cfg_data);
				REG_TANGENTIAL_P1: p1_q       <= $signed(cfg_data);
				REG_TANGENTIAL_P2: p2_q       <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// A zero focal length acts as the smallest step.
	logic [FOCAL_W-1:0] fx;
	logic [FOCAL_W-1:0] fy;

	assign fx = (focal_x_q == '0) ? FOCAL_W'(1) : focal_x_q;
	assign fy = (focal_y_q == '0) ? FOCAL_W'(1) : focal_y_q;

	// The pipeline never stalls, so every request is taken.
	logic accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Normalization of both axes.
	norm_t nx;
	norm_t ny;

	ldpm_norm u_norm_x (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (accept),
		.pix    (in_x),
		.centre (centre_x_q),
		.focal  (fx),
		.result (nx)
	);

	ldpm_norm u_norm_y (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (accept),
		.pix    (in_y),
		.centre (centre_y_q),
		.focal  (fy),
		.result (ny)
	);

	// Valid and saturation flags travel down the arithmetic stages.
	logic                v_s [1:POST_LATENCY];
	logic                sat_s1, sat_s2, sat_s3, sat_s4, sat_s5;
	logic                sat_s6, sat_s7, sat_s8, sat_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= POST_LATENCY; i++) begin
				v_s[i] <= 1'b0;
			end
		end else begin
			v_s[1] <= nx.valid & ny.valid;
			for (int i = 2; i <= POST_LATENCY; i++) begin
				v_s[i] <= v_s[i-1];
			end
		end
	end

	// Stage 1: squares and cross product.
	logic signed [NORM_W-1:0] xn_s1, yn_s1;
	logic signed [53:0]       x2p_s1, y2p_s1, xyp_s1;

	always_ff @(posedge clk) begin
		xn_s1  <= nx.value;
		yn_s1  <= ny.value;
		sat_s1 <= nx.sat | ny.sat;
		x2p_s1 <= nx.value * nx.value;
		y2p_s1 <= ny.value * ny.value;
		xyp_s1 <= nx.value * ny.value;
	end

	// Stage 2: round to Q.24 and form r^2.
	logic signed [54:0] x2_t, y2_t, xy_t;
	logic signed [27:0] x2_c, y2_c, xy_c;
	logic signed [28:0] r2_c;
	logic signed [NORM_W-1:0] xn_s2, yn_s2;
	logic signed [27:0] x2_s2, y2_s2, xy_s2;
	logic signed [28:0] r2_s2;

	assign x2_t = x2p_s1 + (55'sd1 <<< 23);
	assign y2_t = y2p_s1 + (55'sd1 <<< 23);
	assign xy_t = xyp_s1 + (55'sd1 <<< 23);
	assign x2_c = x2_t[51:24];
	assign y2_c = y2_t[51:24];
	assign xy_c = xy_t[51:24];
	assign r2_c = x2_c + y2_c;

	always_ff @(posedge clk) begin
		xn_s2  <= xn_s1;
		yn_s2  <= yn_s1;
		sat_s2 <= sat_s1;
		x2_s2  <= x2_c;
		y2_s2  <= y2_c;
		xy_s2  <= xy_c;
		r2_s2  <= r2_c;
	end

	// Stage 3: coefficient products.
	logic signed [29:0] ax_c, ay_c;
	logic signed [NORM_W-1:0] xn_s3, yn_s3;
	logic signed [28:0] r2_s3;
	logic signed [60:0] k2r2_s3;
	logic signed [59:0] p1xy_s3, p2xy_s3;
	logic signed [61:0] p2ax_s3, p1ay_s3;

	assign ax_c = r2_s2 + (x2_s2 <<< 1);
	assign ay_c = r2_s2 + (y2_s2 <<< 1);

	always_ff @(posedge clk) begin
		xn_s3   <= xn_s2;
		yn_s3   <= yn_s2;
		sat_s3  <= sat_s2;
		r2_s3   <= r2_s2;
		k2r2_s3 <= k2_q * r2_s2;
		p1xy_s3 <= p1_q * xy_s2;
		p2xy_s3 <= p2_q * xy_s2;
		p2ax_s3 <= p2_q * ax_c;
		p1ay_s3 <= p1_q * ay_c;
	end

	// Stage 4: radial inner term and tangential offsets.
	logic signed [32:0] rk1_t;
	logic signed [28:0] rk1_c;
	logic signed [61:0] rk2_t;
	logic signed [31:0] rk2_c;
	logic signed [31:0] inner_c;
	logic signed [60:0] p1xy_t, p2xy_t;
	logic signed [62:0] p2ax_t, p1ay_t;
	logic signed [31:0] p1xy_c, p2xy_c;
	logic signed [32:0] p2ax_c, p1ay_c;
	logic signed [33:0] tx_c, ty_c;
	logic signed [NORM_W-1:0] xn_s4, yn_s4;
	logic signed [28:0] r2_s4;
	logic signed [31:0] inner_s4;
	logic signed [33:0] tx_s4, ty_s4;

	assign rk1_t   = k1_q + (33'sd1 <<< 3);
	assign rk1_c   = rk1_t[32:4];
	assign rk2_t   = k2r2_s3 + (62'sd1 <<< 27);
	assign rk2_c   = rk2_t[59:28];
	assign inner_c = rk1_c + rk2_c;

	// Doubled products round at one bit less.
	assign p1xy_t = p1xy_s3 + (61'sd1 <<< 26);
	assign p2xy_t = p2xy_s3 + (61'sd1 <<< 26);
	assign p2ax_t = p2ax_s3 + (63'sd1 <<< 27);
	assign p1ay_t = p1ay_s3 + (63'sd1 <<< 27);
	assign p1xy_c = p1xy_t[58:27];
	assign p2xy_c = p2xy_t[58:27];
	assign p2ax_c = p2ax_t[60:28];
	assign p1ay_c = p1ay_t[60:28];
	assign tx_c   = p1xy_c + p2ax_c;
	assign ty_c   = p1ay_c + p2xy_c;

	always_ff @(posedge clk) begin
		xn_s4    <= xn_s3;
		yn_s4    <= yn_s3;
		sat_s4   <= sat_s3;
		r2_s4    <= r2_s3;
		inner_s4 <= inner_c;
		tx_s4    <= tx_c;
		ty_s4    <= ty_c;
	end

	// Stage 5: inner term times r^2.
	logic signed [NORM_W-1:0] xn_s5, yn_s5;
	logic signed [60:0] ir_s5;
	logic signed [33:0] tx_s5, ty_s5;

	always_ff @(posedge clk) begin
		xn_s5  <= xn_s4;
		yn_s5  <= yn_s4;
		sat_s5 <= sat_s4;
		tx_s5  <= tx_s4;
		ty_s5  <= ty_s4;
		ir_s5  <= inner_s4 * r2_s4;
	end

	// Stage 6: radial factor, one plus the rounded term.
	logic signed [61:0] ir_t;
	logic signed [34:0] ir_c;
	logic signed [35:0] radial_c;
	logic signed [NORM_W-1:0] xn_s6, yn_s6;
	logic signed [35:0] radial_s6;
	logic signed [33:0] tx_s6, ty_s6;

	assign ir_t     = ir_s5 + (62'sd1 <<< 23);
	assign ir_c     = ir_t[58:24];
	assign radial_c = ir_c + (36'sd1 <<< 24);

	always_ff @(posedge clk) begin
		xn_s6     <= xn_s5;
		yn_s6     <= yn_s5;
		sat_s6    <= sat_s5;
		tx_s6     <= tx_s5;
		ty_s6     <= ty_s5;
		radial_s6 <= radial_c;
	end

	// Stage 7: scale each axis by the radial factor.
	logic signed [62:0] xr_s7, yr_s7;
	logic signed [33:0] tx_s7, ty_s7;

	always_ff @(posedge clk) begin
		sat_s7 <= sat_s6;
		tx_s7  <= tx_s6;
		ty_s7  <= ty_s6;
		xr_s7  <= xn_s6 * radial_s6;
		yr_s7  <= yn_s6 * radial_s6;
	end

	// Stage 8: distorted normalized point.
	logic signed [63:0] xr_t, yr_t;
	logic signed [36:0] xr_c, yr_c;
	logic signed [37:0] xd_c, yd_c;
	logic signed [37:0] xd_s8, yd_s8;

	assign xr_t = xr_s7 + (64'sd1 <<< 23);
	assign yr_t = yr_s7 + (64'sd1 <<< 23);
	assign xr_c = xr_t[60:24];
	assign yr_c = yr_t[60:24];
	assign xd_c = xr_c + tx_s7;
	assign yd_c = yr_c + ty_s7;

	always_ff @(posedge clk) begin
		sat_s8 <= sat_s7;
		xd_s8  <= xd_c;
		yd_s8  <= yd_c;
	end

	// Stage 9: back to pixel scale.
	logic signed [62:0] xf_s9, yf_s9;

	always_ff @(posedge clk) begin
		sat_s9 <= sat_s8;
		xf_s9  <= xd_s8 * $signed({1'b0, fx});
		yf_s9  <= yd_s8 * $signed({1'b0, fy});
	end

	// Stage 10: round, add the principal point and clamp to Q15.8.
	logic signed [63:0] xf_t, yf_t;
	logic signed [38:0] xf_c, yf_c;
	logic signed [39:0] xv_c, yv_c;
	logic               xhi, xlo, yhi, ylo;
	logic signed [COORD_W-1:0] out_x_s10, out_y_s10;
	logic               sat_s10;

	assign xf_t = xf_s9 + (64'sd1 <<< 23);
	assign yf_t = yf_s9 + (64'sd1 <<< 23);
	assign xf_c = xf_t[62:24];
	assign yf_c = yf_t[62:24];
	assign xv_c = xf_c + $signed({16'd0, centre_x_q});
	assign yv_c = yf_c + $signed({16'd0, centre_y_q});
	assign xhi  = xv_c > 40'sd8388607;
	assign xlo  = xv_c < -40'sd8388608;
	assign yhi  = yv_c > 40'sd8388607;
	assign ylo  = yv_c < -40'sd8388608;

	always_ff @(posedge clk) begin
		sat_s10   <= sat_s9 | xhi | xlo | yhi | ylo;
		out_x_s10 <= xhi ? 24'sh7FFFFF : (xlo ? -24'sh800000 : xv_c[COORD_W-1:0]);
		out_y_s10 <= yhi ? 24'sh7FFFFF : (ylo ? -24'sh800000 : yv_c[COORD_W-1:0]);
	end

	assign done      = v_s[POST_LATENCY];
	assign out_x     = out_x_s10;
	assign out_y     = out_y_s10;
	assign saturated = sat_s10;

endmodule

[rtl/ldpm_checker.sv]
// ----------------------------------------------------------------------------
// ldpm_checker - port-level checks for the lens distortion point map
// Checks the fixed request-to-result latency and that busy never blocks.
// ----------------------------------------------------------------------------
module ldpm_checker
	import ldpm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// The pipeline takes a request in every cycle.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised although the pipeline never stalls");

	// Every request yields a result after the pipeline latency.
	a_request_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LATENCY done)
		else $error("request was lost in the pipeline");

	// Every result comes from a request taken one latency earlier.
	a_done_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LATENCY))
		else $error("result without a matching request");

endmodule

bind lens_distortion_point_map ldpm_checker u_ldpm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

[verif/ldpm_result_checker.sv]
// ----------------------------------------------------------------------------
// ldpm_result_checker - result checker for the lens distortion point map
// Watches the request, result and register write ports, predicts each
// distorted point in 64-bit fixed point and compares it with the block output.
// ----------------------------------------------------------------------------
module ldpm_result_checker
	import ldpm_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic signed [COORD_W-1:0] in_x,
	input  logic signed [COORD_W-1:0] in_y,
	input  logic                      done,
	input  logic signed [COORD_W-1:0] out_x,
	input  logic signed [COORD_W-1:0] out_y,
	input  logic                      saturated,
	input  logic                      cfg_write,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	output int                        outstanding,
	output int                        fail_count
);

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      sat;
	} distorted_point_t;

	// Shadow copy of the lens registers.
	logic [FOCAL_W-1:0]       lens_fx, lens_fy, lens_cx, lens_cy;
	logic signed [COEF_W-1:0] lens_k1, lens_k2, lens_p1, lens_p2;

	distorted_point_t pending_points[$];
	distorted_point_t want;
	int               mismatches;
	int               results_seen;

	// Shift right by s with round to nearest, ties toward plus infinity.
	function automatic longint round_shift(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// Pixel offset from the principal point divided by the focal length, in Q.24.
	// The quotient rounds half away from zero and is clamped to +/-2.0.
	function automatic longint norm_axis(input longint pix, input longint ctr,
			input longint foc, inout logic clamp);
		longint d, mag, f, q;
		d = pix - ctr;
		f = (foc == 0) ? longint'(1) : foc;
		mag = (d < 0) ? -d : d;
		q = ((mag <<< 24) + (f >>> 1)) / f;
		if (q > (longint'(1) <<< 25)) begin
			q = longint'(1) <<< 25;
			clamp = 1'b1;
		end
		return (d < 0) ? -q : q;
	endfunction

	// Scale a distorted Q.24 value back to Q15.8 pixels and saturate.
	function automatic logic signed [COORD_W-1:0] pixel_axis(input longint nd,
			input longint ctr, input longint foc, inout logic clamp);
		longint f, v;
		f = (foc == 0) ? longint'(1) : foc;
		v = round_shift(nd * f, 24) + ctr;
		if (v > 64'sd8388607) begin
			v = 64'sd8388607;
			clamp = 1'b1;
		end
		if (v < -64'sd8388608) begin
			v = -64'sd8388608;
			clamp = 1'b1;
		end
		return v[COORD_W-1:0];
	endfunction

	// Brown-Conrady mapping of one ideal point with the current registers.
	function automatic distorted_point_t distort_point(input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py);
		distorted_point_t r;
		logic   clamp;
		longint xn, yn, x2, y2, xy, r2, inner, radial, tx, ty, xd, yd;
		clamp = 1'b0;
		xn = norm_axis(longint'(px), longint'(lens_cx), longint'(lens_fx), clamp);
		yn = norm_axis(longint'(py), longint'(lens_cy), longint'(lens_fy), clamp);
		x2 = round_shift(xn * xn, 24);
		y2 = round_shift(yn * yn, 24);
		xy = round_shift(xn * yn, 24);
		r2 = x2 + y2;
		inner = round_shift(longint'(lens_k1), 4) + round_shift(longint'(lens_k2) * r2, 28);
		radial = (longint'(1) <<< 24) + round_shift(inner * r2, 24);
		tx = round_shift(2 * longint'(lens_p1) * xy, 28)
			+ round_shift(longint'(lens_p2) * (r2 + 2 * x2), 28);
		ty = round_shift(longint'(lens_p1) * (r2 + 2 * y2), 28)
			+ round_shift(2 * longint'(lens_p2) * xy, 28);
		xd = round_shift(xn * radial, 24) + tx;
		yd = round_shift(yn * radial, 24) + ty;
		r.x = pixel_axis(xd, longint'(lens_cx), longint'(lens_fx), clamp);
		r.y = pixel_axis(yd, longint'(lens_cy), longint'(lens_fy), clamp);
		r.sat = clamp;
		return r;
	endfunction

	// Compare results, queue predictions for accepted requests, track register writes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lens_fx <= FOCAL_RESET;
			lens_fy <= FOCAL_RESET;
			lens_cx <= '0;
			lens_cy <= '0;
			lens_k1 <= '0;
			lens_k2 <= '0;
			lens_p1 <= '0;
			lens_p2 <= '0;
			pending_points.delete();
			mismatches = 0;
			results_seen = 0;
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			if (done) begin
				results_seen++;
				if (pending_points.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: result %0d arrived with no request pending: x=%0d y=%0d sat=%0b",
							results_seen, out_x, out_y, saturated);
				end else begin
					want = pending_points.pop_front();
					if (out_x !== want.x || out_y !== want.y || saturated !== want.sat) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: result %0d expected x=%0d y=%0d sat=%0b, got x=%0d y=%0d sat=%0b",
								results_seen, want.x, want.y, want.sat, out_x, out_y, saturated);
					end
				end
			end
			if (start && !busy)
				pending_points.insert(pending_points.size(), distort_point(in_x, in_y));
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_FOCAL_X:       lens_fx <= cfg_data[FOCAL_W-1:0];
					REG_FOCAL_Y:       lens_fy <= cfg_data[FOCAL_W-1:0];
					REG_CENTRE_X:      lens_cx <= cfg_data[FOCAL_W-1:0];
					REG_CENTRE_Y:      lens_cy <= cfg_data[FOCAL_W-1:0];
					REG_RADIAL_K1:     lens_k1 <= cfg_data;
					REG_RADIAL_K2:     lens_k2 <= cfg_data;
					REG_TANGENTIAL_P1: lens_p1 <= cfg_data;
					REG_TANGENTIAL_P2: lens_p2 <= cfg_data;
					default: ;
				endcase
			end
			outstanding <= pending_points.size();
			fail_count <= mismatches;
		end
	end

endmodule

[verif/tb_lens_distortion_point_map.sv]
// ----------------------------------------------------------------------------
// tb_lens_distortion_point_map - testbench for the lens distortion point map
// Drives directed and random points under several lens setups and request
// gap rates; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lens_distortion_point_map;
	import ldpm_pkg::*;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic signed [COORD_W-1:0] in_x = '0;
	logic signed [COORD_W-1:0] in_y = '0;
	logic                      done;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic                      saturated;
	logic                      cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = REG_FOCAL_X;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;
	int                        outstanding;
	int                        fail_count;

	// Lens setup last written, used to aim points at the image area.
	logic [FOCAL_W-1:0] cur_fx = FOCAL_RESET;
	logic [FOCAL_W-1:0] cur_fy = FOCAL_RESET;
	logic [FOCAL_W-1:0] cur_cx = '0;
	logic [FOCAL_W-1:0] cur_cy = '0;
	int                 idle_pct = 0;

	lens_distortion_point_map dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.in_x      (in_x),
		.in_y      (in_y),
		.done      (done),
		.out_x     (out_x),
		.out_y     (out_y),
		.saturated (saturated),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ldpm_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.in_x        (in_x),
		.in_y        (in_y),
		.done        (done),
		.out_x       (out_x),
		.out_y       (out_y),
		.saturated   (saturated),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Write all eight lens registers on back-to-back cycles. The unused upper
	// byte of the 24-bit registers carries random bits.
	task automatic write_config(input logic [23:0] fx, fy, cx, cy,
			input logic [31:0] k1, k2, p1, p2);
		cfg_reg_t    order [8];
		logic [31:0] vals [8];
		order = '{REG_FOCAL_X, REG_FOCAL_Y, REG_CENTRE_X, REG_CENTRE_Y,
			REG_RADIAL_K1, REG_RADIAL_K2, REG_TANGENTIAL_P1, REG_TANGENTIAL_P2};
		vals = '{{8'($urandom), fx}, {8'($urandom), fy}, {8'($urandom), cx},
			{8'($urandom), cy}, k1, k2, p1, p2};
		for (int i = 0; i < 8; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		cur_fx = fx;
		cur_fy = fy;
		cur_cx = cx;
		cur_cy = cy;
	endtask

	// Issue one request after a random number of idle cycles.
	task automatic send_point(input logic [23:0] x, input logic [23:0] y);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			in_x <= 24'($urandom);
			in_y <= 24'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		in_x <= x;
		in_y <= y;
		do @(posedge clk); while (busy);
	endtask

	// Stop requesting and wait until every predicted result has come back.
	task automatic drain_pipeline();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Stimulus: directed corners and special setups, then random phases.
	initial begin
		longint px, py, span;
		int     kind;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default registers: unit focal length, so large coordinates hit the
		// normalized clamp; exactly 2.0 must not clamp, just above must.
		idle_pct = 27;
		send_point(24'd0, 24'd0);
		send_point(24'h7FFFFF, 24'h7FFFFF);
		send_point(24'h800000, 24'h800000);
		send_point(24'h7FFFFF, 24'h800000);
		send_point(-24'sd1, 24'd1);
		send_point(24'd256, -24'sd256);
		send_point(24'd512, -24'sd512);
		send_point(24'd513, 24'd0);
		drain_pipeline();

		// A typical camera: 1000 px focal length, 1280x720 image, barrel distortion.
		write_config(24'd256000, 24'd256000, 24'd163840, 24'd92160,
			-32'sd80530637, 32'sd26843546, 32'sd268435, -32'sd134218);
		send_point(24'd163840, 24'd92160);
		send_point(24'd0, 24'd0);
		send_point(24'd327680, 24'd184320);
		send_point(24'd0, 24'd184320);
		send_point(24'd327680, 24'd0);
		send_point(24'h7FFFFF, 24'h800000);
		drain_pipeline();

		// Extreme registers: zero focal length, full-scale focal and centre,
		// coefficients at both ends; outputs run into the clamp.
		write_config(24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0,
			32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
		send_point(24'd0, 24'd0);
		send_point(24'h7FFFFF, 24'h7FFFFF);
		send_point(24'h800000, 24'd1);
		send_point(-24'sd1, 24'h800000);
		drain_pipeline();
		write_config(24'hFFFFFF, 24'd1, 24'd0, 24'hFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
		send_point(24'h7FFFFF, 24'd0);
		send_point(24'h800000, 24'h7FFFFF);
		send_point(24'd0, 24'h800000);
		drain_pipeline();

		// Random phases: mostly plausible lenses, every fourth with random bits.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 3)
				0: idle_pct = 0;
				1: idle_pct = 75;
				default: idle_pct = 27;
			endcase
			if (phase % 4 == 3)
				write_config(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
					$urandom, $urandom, $urandom, $urandom);
			else
				write_config(24'($urandom_range(64, 4096) * 256 + $urandom_range(0, 255)),
					24'($urandom_range(64, 4096) * 256 + $urandom_range(0, 255)),
					24'($urandom_range(0, 4000) * 256 + $urandom_range(0, 255)),
					24'($urandom_range(0, 4000) * 256 + $urandom_range(0, 255)),
					32'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000,
					32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000,
					32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000,
					32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000);
			for (int n = 0; n < 240; n++) begin
				kind = $urandom_range(0, 9);
				if (kind < 2) begin
					px = longint'($urandom);
					py = longint'($urandom);
				end else if (kind == 2) begin
					px = longint'(cur_cx) + $urandom_range(0, 128) - 64;
					py = longint'(cur_cy) + $urandom_range(0, 128) - 64;
				end else begin
					// Within about two focal lengths of the principal point.
					span = 2 * longint'(cur_fx);
					px = longint'(cur_cx) + longint'($urandom_range(0, 32'(2 * span))) - span;
					span = 2 * longint'(cur_fy);
					py = longint'(cur_cy) + longint'($urandom_range(0, 32'(2 * span))) - span;
				end
				send_point(px[23:0], py[23:0]);
				// Once, hold off until the pipeline has emptied.
				if (phase == 1 && n == 120)
					drain_pipeline();
			end
			drain_pipeline();
		end

		repeat (PIPE_LATENCY + 4) @(posedge clk);
		if (fail_count == 0)
			$display("lens_distortion_point_map: match");
		else
			$display("lens_distortion_point_map: mismatch");
		$finish;
	end

	// Watchdog against a hung pipeline.
	initial begin
		#8000000;
		$display("lens_distortion_point_map: mismatch");
		$finish;
	end

endmodule

[filelist.f]
rtl/ldpm_pkg.sv
rtl/ldpm_norm.sv
rtl/lens_distortion_point_map.sv
rtl/ldpm_checker.sv
verif/ldpm_result_checker.sv
verif/tb_lens_distortion_point_map.sv
